/* hw/rtl/double_sampled_svf_assert.svh */
// Assertion macros shared by the filter RTL.
`ifndef DOUBLE_SAMPLED_SVF_ASSERT_SVH
`define DOUBLE_SAMPLED_SVF_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define DSVF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define DSVF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/dsvf_pkg.sv */
// Types, constants and saturation helpers for the double-sampled filter.
package dsvf_pkg;

  localparam logic [23:0] FreqReset = 24'd1048576;

  typedef enum logic [1:0] {
    REG_FREQ  = 2'd0,
    REG_DAMP  = 2'd1,
    REG_DRIVE = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MD,
    ST_MF,
    ST_MSQ,
    ST_LOW,
    ST_MCUBE,
    ST_MFH,
    ST_MDRV,
    ST_SUM,
    ST_BAND,
    ST_OUT
  } st_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DAMP_BAND,
    OP_FREQ_BAND,
    OP_BAND_SQ,
    OP_SQ_BAND,
    OP_FREQ_HIGH,
    OP_DRIVE_CUBE
  } mul_op_e;

  typedef struct packed {
    mul_op_e mul_op;
    logic    ld_notch;
    logic    ld_low;
    logic    ld_high;
    logic    ld_sum;
    logic    ld_band;
    logic    first_pass;
    logic    ld_out;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if ((&x[33:31]) || !(|x[33:31])) return x[31:0];
    return x[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [34:0] x);
    if ((&x[34:23]) || !(|x[34:23])) return x[23:0];
    return x[34] ? 24'sh80_0000 : 24'sh7f_ffff;
  endfunction

  // sum of both passes -> average, round half up, clamp to Q1.23
  function automatic logic signed [23:0] pack24(input logic signed [34:0] s);
    logic signed [34:0] r;
    r = (s + 35'sd1) >>> 1;
    return sat24(r);
  endfunction

endpackage

/* hw/rtl/dsvf_mul.sv */
// Shared multiplier: registered product, then round, shift and saturate to Q9.23.
module dsvf_mul
  import dsvf_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [32:0] op_a_i,
  input  logic signed [31:0] op_b_i,
  input  logic               state_scale_i,
  output logic signed [31:0] res_o
);

  logic signed [64:0] prod_d, prod_q;
  logic               scale_q;
  logic signed [64:0] rnd, shf;
  logic signed [31:0] res_d, res_q;

  assign prod_d = op_a_i * op_b_i;

  // state x state is Q.46 -> shift 23, coef x state is Q.45 -> shift 22
  always_comb begin
    rnd = prod_q + (scale_q ? 65'sd4194304 : 65'sd2097152);
    shf = scale_q ? (rnd >>> 23) : (rnd >>> 22);
    if ((&shf[64:31]) || !(|shf[64:31])) begin
      res_d = shf[31:0];
    end else begin
      res_d = shf[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    scale_q <= state_scale_i;
    res_q   <= res_d;
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/dsvf_ctrl.sv */
// Sequencer: steps the shared multiplier through two filter passes per sample.
`include "double_sampled_svf_assert.svh"
module dsvf_ctrl
  import dsvf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_free_i,
  output ctl_t ctl_o
);

  st_e  state_d, state_q;
  logic pass_d, pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // product issued in a step is readable once it has passed the multiplier's product and result registers
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.mul_op = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MD;
          pass_d  = 1'b0;
        end
      end
      ST_MD: begin
        ctl_o.mul_op = OP_DAMP_BAND;
        state_d = ST_MF;
      end
      ST_MF: begin
        ctl_o.mul_op = OP_FREQ_BAND;
        state_d = ST_MSQ;
      end
      ST_MSQ: begin
        ctl_o.mul_op   = OP_BAND_SQ;
        ctl_o.ld_notch = 1'b1;
        state_d = ST_LOW;
      end
      ST_LOW: begin
        ctl_o.ld_low = 1'b1;
        state_d = ST_MCUBE;
      end
      ST_MCUBE: begin
        ctl_o.mul_op  = OP_SQ_BAND;
        ctl_o.ld_high = 1'b1;
        state_d = ST_MFH;
      end
      ST_MFH: begin
        ctl_o.mul_op = OP_FREQ_HIGH;
        state_d = ST_MDRV;
      end
      ST_MDRV: begin
        ctl_o.mul_op = OP_DRIVE_CUBE;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        ctl_o.ld_sum = 1'b1;
        state_d = ST_BAND;
      end
      ST_BAND: begin
        ctl_o.ld_band    = 1'b1;
        ctl_o.first_pass = !pass_q;
        if (pass_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MD;
          pass_d  = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          ctl_o.ld_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `DSVF_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == ST_MD && !pass_q), "transfer did not start pass one")
  `DSVF_ASSERT(a_second_pass, (state_q == ST_BAND && !pass_q) |=> (state_q == ST_MD && pass_q), "pass two not entered")
  `DSVF_ASSERT(a_to_output, (state_q == ST_BAND && pass_q) |=> (state_q == ST_OUT), "output step skipped")

endmodule

/* hw/rtl/double_sampled_svf.sv */
// Double-sampled state-variable filter with cubic drive: registers, datapath, outputs.
// Each sample takes two 9-step passes plus the output step, which waits only while the
// output register is still occupied; a new sample is taken only in the idle step, once
// the last one has gone to the output. The shared 33x32 multiplier is used six times per
// pass, and both its product and its result are registered.
// Reset: low and band states and damp and drive clear to zero, freq coefficient to 0.25.
`include "double_sampled_svf_assert.svh"
module double_sampled_svf
  import dsvf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] low_out_o,
  output logic signed [23:0] high_out_o,
  output logic signed [23:0] band_out_o,
  output logic signed [23:0] peak_out_o,
  output logic signed [23:0] notch_out_o
);

  ctl_t ctl;
  logic out_valid_q;
  logic out_free;

  logic [23:0] freq_q, damp_q, drive_q;
  logic signed [23:0] x_q;
  logic signed [31:0] low_q, band_q, notch_q, high_q;
  logic signed [32:0] sum_q;
  logic signed [32:0] acc_low_q, acc_high_q, acc_band_q, acc_notch_q;
  logic signed [33:0] acc_peak_q;
  logic signed [23:0] low_o_q, high_o_q, band_o_q, peak_o_q, notch_o_q;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_scale;
  logic signed [31:0] mres;

  logic signed [31:0] notch_n, low_n, high_n, band_n;
  logic signed [32:0] sum_n, peak_n;

  assign out_free = !out_valid_q || out_ready_i;

  dsvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_scale = 1'b0;
    unique case (ctl.mul_op)
      OP_DAMP_BAND: begin
        mul_a = {9'b0, damp_q};
        mul_b = band_q;
      end
      OP_FREQ_BAND: begin
        mul_a = {9'b0, freq_q};
        mul_b = band_q;
      end
      OP_BAND_SQ: begin
        mul_a     = {band_q[31], band_q};
        mul_b     = band_q;
        mul_scale = 1'b1;
      end
      OP_SQ_BAND: begin
        mul_a     = {band_q[31], band_q};
        mul_b     = mres;
        mul_scale = 1'b1;
      end
      OP_FREQ_HIGH: begin
        mul_a = {9'b0, freq_q};
        mul_b = high_q;
      end
      OP_DRIVE_CUBE: begin
        mul_a = {9'b0, drive_q};
        mul_b = mres;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  dsvf_mul u_mul (
    .clk_i         (clk_i),
    .op_a_i        (mul_a),
    .op_b_i        (mul_b),
    .state_scale_i (mul_scale),
    .res_o         (mres)
  );

  always_comb begin
    notch_n = sat32({{10{x_q[23]}}, x_q} - {{2{mres[31]}}, mres});
    low_n   = sat32({{2{low_q[31]}}, low_q} + {{2{mres[31]}}, mres});
    high_n  = sat32({{2{notch_q[31]}}, notch_q} - {{2{low_q[31]}}, low_q});
    sum_n   = {mres[31], mres} + {band_q[31], band_q};
    band_n  = sat32({sum_q[32], sum_q} - {{2{mres[31]}}, mres});
    peak_n  = {low_q[31], low_q} - {high_q[31], high_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= FreqReset;
      damp_q  <= '0;
      drive_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FREQ:  freq_q  <= cfg_data_i;
        REG_DAMP:  damp_q  <= cfg_data_i;
        REG_DRIVE: drive_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      band_q <= '0;
    end else begin
      if (ctl.ld_low)  low_q  <= low_n;
      if (ctl.ld_band) band_q <= band_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) x_q <= sample_in_i;
    if (ctl.ld_notch) notch_q <= notch_n;
    if (ctl.ld_high)  high_q  <= high_n;
    if (ctl.ld_sum)   sum_q   <= sum_n;
    if (ctl.ld_band) begin
      acc_low_q   <= (ctl.first_pass ? 33'sd0 : acc_low_q) + {low_q[31], low_q};
      acc_high_q  <= (ctl.first_pass ? 33'sd0 : acc_high_q) + {high_q[31], high_q};
      acc_band_q  <= (ctl.first_pass ? 33'sd0 : acc_band_q) + {band_n[31], band_n};
      acc_notch_q <= (ctl.first_pass ? 33'sd0 : acc_notch_q) + {notch_q[31], notch_q};
      acc_peak_q  <= (ctl.first_pass ? 34'sd0 : acc_peak_q) + {peak_n[32], peak_n};
    end
    if (ctl.ld_out) begin
      low_o_q   <= pack24({{2{acc_low_q[32]}}, acc_low_q});
      high_o_q  <= pack24({{2{acc_high_q[32]}}, acc_high_q});
      band_o_q  <= pack24({{2{acc_band_q[32]}}, acc_band_q});
      peak_o_q  <= pack24({acc_peak_q[33], acc_peak_q});
      notch_o_q <= pack24({{2{acc_notch_q[32]}}, acc_notch_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign low_out_o   = low_o_q;
  assign high_out_o  = high_o_q;
  assign band_out_o  = band_o_q;
  assign peak_out_o  = peak_o_q;
  assign notch_out_o = notch_o_q;

  `DSVF_ASSERT(a_load_sets_valid, ctl.ld_out |=> out_valid_o, "output load did not raise valid")
  `DSVF_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(ctl.ld_out), "valid rose without a load")
  `DSVF_NEVER(a_ready_while_busy, in_ready_o && (ctl.ld_notch || ctl.ld_band), "ready during a pass")

endmodule
